/* src/vwma_pkg.sv */
// ----------------------------------------------------------------------------
// vwma_pkg
// Widths shared by the variable-window moving average.
// ----------------------------------------------------------------------------
package vwma_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 7;
    // largest window is 127 samples of 16 bits, so 23 bits hold any sum
    localparam int SUM_W    = SAMPLE_W + LEN_W;
    localparam int STEP_W   = $clog2(SUM_W);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

endpackage

/* src/variable_window_moving_average.sv */
// ----------------------------------------------------------------------------
// variable_window_moving_average
// Moving average over the newest window_len samples, quotient toward zero.
// ----------------------------------------------------------------------------
// Each accepted word stores its sample in a ring of MAX_WINDOW entries and
// returns the mean of the newest n samples, n being window_len clamped to
// 1..MAX_WINDOW (and to at most 127). Samples never written since reset count
// as zero, tracked by a fill count, so no clearing pass is needed. Each word
// walks the ring through its single registered read port, forms the
// magnitude, runs a one-bit-per-cycle restoring divider, loads the output
// register and returns to idle, where ready rises again. The load waits
// while the output register still holds an unaccepted word. A finished
// result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module variable_window_moving_average #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: window_len
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vwma_pkg::LEN_W-1:0]    cfg_data,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vwma_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vwma_pkg::SAMPLE_W-1:0] m_tdata    // [15:0] average
);

    import vwma_pkg::*;

    localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW      = $clog2(MAX_WINDOW + 1);
    localparam int CMPW    = (CW > LEN_W) ? CW : LEN_W;
    localparam int LEN_MAX = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;

    state_t                    state_reg, state_next;
    logic [LEN_W-1:0]          window_len_reg, window_len_next;
    logic [LEN_W-1:0]          n_reg, n_next;
    logic [LEN_W-1:0]          k_reg, k_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [AW-1:0]             rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      fetch_reg, fetch_next;
    logic                      hit_reg, hit_next;
    logic signed [SUM_W-1:0]   acc_reg, acc_next;
    logic [SUM_W-1:0]          dq_reg, dq_next;
    logic [LEN_W-1:0]          rem_reg, rem_next;
    logic                      neg_reg, neg_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]       m_tdata_reg, m_tdata_next;

    logic                      in_fire;
    logic [AW-1:0]             head_inc;
    logic [LEN_W-1:0]          eff_len;
    logic [LEN_W:0]            trial;
    logic                      trial_ge;
    logic [SUM_W-1:0]          quo_signed;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign in_fire   = s_tvalid && s_tready;

    assign head_inc = (head_reg == AW'(MAX_WINDOW - 1)) ? '0 : head_reg + AW'(1);

    always_comb
    begin
        eff_len = window_len_reg;
        if (eff_len == '0)
        begin
            eff_len = LEN_W'(1);
        end
        if (eff_len > LEN_W'(LEN_MAX))
        begin
            eff_len = LEN_W'(LEN_MAX);
        end
    end

    assign trial      = {rem_reg, dq_reg[SUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, n_reg});
    assign quo_signed = neg_reg ? (~dq_reg + SUM_W'(1)) : dq_reg;

    // ring storage, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mem[head_inc] <= s_tdata;
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        window_len_next = window_len_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        head_next       = head_reg;
        rd_ptr_next     = rd_ptr_reg;
        cnt_next        = cnt_reg;
        fetch_next      = 1'b0;
        hit_next        = hit_reg;
        acc_next        = acc_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        neg_next        = neg_reg;
        step_next       = step_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            window_len_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    head_next   = head_inc;
                    rd_ptr_next = head_reg;
                    cnt_next    = (cnt_reg == CW'(MAX_WINDOW)) ? cnt_reg : cnt_reg + CW'(1);
                    n_next      = eff_len;
                    k_next      = LEN_W'(1);
                    acc_next    = SUM_W'(signed'(s_tdata));
                    state_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                if (fetch_reg && hit_reg)
                begin
                    acc_next = acc_reg + SUM_W'(signed'(rd_data_reg));
                end
                if (k_reg < n_reg)
                begin
                    fetch_next  = 1'b1;
                    hit_next    = (CMPW'(k_reg) < CMPW'(cnt_reg));
                    rd_ptr_next = (rd_ptr_reg == '0) ? AW'(MAX_WINDOW - 1)
                                                     : rd_ptr_reg - AW'(1);
                    k_next      = k_reg + LEN_W'(1);
                end
                else if (!fetch_reg)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                neg_next   = acc_reg[SUM_W-1];
                dq_next    = acc_reg[SUM_W-1] ? (~acc_reg + SUM_W'(1)) : acc_reg;
                rem_next   = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = trial_ge ? LEN_W'(trial - {1'b0, n_reg}) : trial[LEN_W-1:0];
                dq_next   = {dq_reg[SUM_W-2:0], trial_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = quo_signed[SAMPLE_W-1:0];
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_len_reg <= LEN_RESET;
            n_reg          <= LEN_W'(1);
            k_reg          <= '0;
            head_reg       <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            fetch_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            acc_reg        <= '0;
            dq_reg         <= '0;
            rem_reg        <= '0;
            neg_reg        <= 1'b0;
            step_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            window_len_reg <= window_len_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            head_reg       <= head_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
            fetch_reg      <= fetch_next;
            hit_reg        <= hit_next;
            acc_reg        <= acc_next;
            dq_reg         <= dq_next;
            rem_reg        <= rem_next;
            neg_reg        <= neg_next;
            step_reg       <= step_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
        end
    end

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg != '0) && (n_reg <= LEN_W'(LEN_MAX)))
        else $error("window length out of range");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_WINDOW))
        else $error("fill count above ring depth");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> (k_reg <= n_reg))
        else $error("ring walk past window");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < n_reg))
        else $error("divider remainder not below divisor");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a word while busy");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the variable-window moving average.
// ----------------------------------------------------------------------------
// Sends signed samples through the input stream and checks every average
// against a local model of the 64-entry delay line. Directed words cover
// full-scale samples, the zero window, a window past the line depth and
// truncation toward zero. Random phases follow, each with its own window
// length, with idle bursts on both sides and two long output hold-offs.
// ----------------------------------------------------------------------------
module tb;
    import vwma_pkg::*;

    localparam int DEPTH         = 64;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int CALM_ITEMS    = 300;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = DEPTH + 60;
    localparam int MAX_PRINTS    = 40;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    class average_scoreboard;
        logic signed [SAMPLE_W-1:0] history [DEPTH];
        logic [LEN_W-1:0]           window_len;
        logic [SAMPLE_W-1:0]        expected_averages [$];
        int                         mismatches;
        int                         averages_checked;

        function new();
            foreach (history[i])
                history[i] = '0;
            window_len       = LEN_RESET;
            mismatches       = 0;
            averages_checked = 0;
        endfunction

        function void set_window(logic [LEN_W-1:0] len);
            window_len = len;
        endfunction

        function int pending();
            return expected_averages.size();
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] sample);
            int n;
            int sum;
            n = window_len;
            if (n < 1)
                n = 1;
            if (n > DEPTH)
                n = DEPTH;
            for (int i = DEPTH - 1; i > 0; i--)
                history[i] = history[i-1];
            history[0] = sample;
            sum = 0;
            for (int i = 0; i < n; i++)
                sum += history[i];
            // int division truncates toward zero
            expected_averages.push_back(SAMPLE_W'(sum / n));
        endfunction

        task report(string msg);
            if (mismatches < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_average(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            if (expected_averages.size() == 0)
            begin
                report($sformatf("average %0d with nothing expected", $signed(got)));
            end
            else
            begin
                want = expected_averages.pop_front();
                averages_checked++;
                if (got !== want)
                    report($sformatf("average %0d, expected %0d (word %0d)",
                                     $signed(got), $signed(want), averages_checked));
            end
        endtask

        task flush_leftovers();
            while (expected_averages.size() != 0)
            begin
                report($sformatf("expected average %0d never arrived",
                                 $signed(expected_averages.pop_front())));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LEN_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;    // [15:0] sample
    logic                m_tvalid;
    logic                m_tready;
    logic [SAMPLE_W-1:0] m_tdata;    // [15:0] average

    average_scoreboard sb;
    int                gap_pct;
    int                stall_pct;
    int                samples_sent;
    int                windows_set;

    variable_window_moving_average #(
        .MAX_WINDOW (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("timeout: %0d averages still outstanding", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_sample(sample);
        samples_sent++;
    endtask

    // only called with the input stream about to go quiet and all averages back
    task automatic set_window(input logic [LEN_W-1:0] len);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_window(len);
        windows_set++;
    endtask

    function automatic logic [LEN_W-1:0] pick_window();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return LEN_W'(1);
            2:       return LEN_W'(2);
            3:       return LEN_W'(DEPTH - 1);
            4:       return LEN_W'(DEPTH);
            5:       return LEN_W'(DEPTH + 1);
            6:       return LEN_MAX;
            7:       return LEN_W'($urandom_range(DEPTH + 1, 127));
            default: return LEN_W'($urandom_range(1, DEPTH));
        endcase
    endfunction

    // style 1 and 2 keep the window near full scale to stress the sum
    function automatic logic [SAMPLE_W-1:0] phase_sample(input int style);
        if (style == 1 && $urandom_range(0, 7) != 0)
            return SAMPLE_W'($urandom_range(32000, 32767));
        if (style == 2 && $urandom_range(0, 7) != 0)
            return 16'h8000 + SAMPLE_W'($urandom_range(0, 767));
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return SAMPLE_W'($urandom_range(0, 15)) - 16'd8;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // output side: random stalls plus two long hold-offs to back up the block
    initial
    begin
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_average(m_tdata);
            if (holds_done < 2 && sb.averages_checked >= 300 + 1000 * holds_done)
            begin
                stall_left = HOLD_CYCLES;
                holds_done++;
            end
            else if (stall_left == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int random_sent;
        int style;
        int count;
        sb           = new();
        gap_pct      = 0;
        stall_pct    = 0;
        samples_sent = 0;
        windows_set  = 0;
        random_sent  = 0;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of one: output follows the sample
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        // zero window behaves as one
        set_window('0);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        // -3/2 must give -1, 3/2 gives 1
        set_window(LEN_W'(2));
        send_sample(-16'sd3);
        send_sample(16'h0000);
        send_sample(16'd3);
        send_sample(16'h0000);
        // window past the line depth clamps to the full line
        set_window(LEN_MAX);
        repeat (4) send_sample(16'h8000);
        repeat (4) send_sample(16'h7FFF);
        set_window(LEN_W'(DEPTH));
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);

        while (random_sent < RANDOM_ITEMS)
        begin
            set_window(pick_window());
            style = $urandom_range(0, 5);
            count = $urandom_range(20, 120);
            if (random_sent >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : 25;
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
            end
            for (int i = 0; i < count && random_sent < RANDOM_ITEMS; i++)
            begin
                send_sample(phase_sample(style));
                random_sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flush_leftovers();

        $display("checked %0d averages from %0d samples over %0d window settings",
                 sb.averages_checked, samples_sent, windows_set);
        $display("windows 0 to 127 incl. clamped ones, idle bursts, two long hold-offs; "
                 , "%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
